// ===== rtl/core/mlk_pkg.sv =====
// mlk_pkg: shared types, constants and code tables of the morse letter keyer
// used by mlk_ctrl, mlk_datapath and morse_letter_keyer_unit; no dependencies
package mlk_pkg;

    localparam int LETTER_W  = 8;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int SYM_MAX   = 4;
    localparam int SYM_CNT_W = 3;
    localparam int IDX_W     = 5;

    localparam logic [LETTER_W-1:0] LETTER_FIRST = 8'd97;
    localparam logic [LETTER_W-1:0] LETTER_LAST  = 8'd122;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_GAP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 8'd3;

    localparam logic [DUR_W-1:0] SYMBOL_GAP_RST = 16'd400;
    localparam logic [DUR_W-1:0] DOT_RST        = 16'd400;
    localparam logic [DUR_W-1:0] DASH_RST       = 16'd1200;
    localparam logic [DUR_W-1:0] LETTER_GAP_RST = 16'd600;

    typedef struct packed {
        logic load;
        logic emit_gap;
        logic emit_mark;
        logic emit_close;
        logic emit_bad;
    } mlk_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic last_sym;
    } mlk_status_t;

    // number of symbols per letter
    function automatic logic [SYM_CNT_W-1:0] code_len(input logic [IDX_W-1:0] idx);
        logic [SYM_CNT_W-1:0] len;
        unique case (idx)
            5'd4, 5'd19: len = 3'd1;
            5'd0, 5'd8, 5'd12, 5'd13: len = 3'd2;
            5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18, 5'd20, 5'd22: len = 3'd3;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

    // symbol bits, first symbol in the highest used bit, 1 is dash
    function automatic logic [SYM_MAX-1:0] code_bits(input logic [IDX_W-1:0] idx);
        logic [SYM_MAX-1:0] bits;
        unique case (idx)
            5'd0:  bits = 4'd1;
            5'd1:  bits = 4'd8;
            5'd2:  bits = 4'd10;
            5'd3:  bits = 4'd4;
            5'd4:  bits = 4'd0;
            5'd5:  bits = 4'd2;
            5'd6:  bits = 4'd6;
            5'd7:  bits = 4'd0;
            5'd8:  bits = 4'd0;
            5'd9:  bits = 4'd7;
            5'd10: bits = 4'd5;
            5'd11: bits = 4'd4;
            5'd12: bits = 4'd3;
            5'd13: bits = 4'd2;
            5'd14: bits = 4'd7;
            5'd15: bits = 4'd6;
            5'd16: bits = 4'd13;
            5'd17: bits = 4'd2;
            5'd18: bits = 4'd0;
            5'd19: bits = 4'd1;
            5'd20: bits = 4'd1;
            5'd21: bits = 4'd1;
            5'd22: bits = 4'd3;
            5'd23: bits = 4'd9;
            5'd24: bits = 4'd11;
            5'd25: bits = 4'd12;
            default: bits = 4'd0;
        endcase
        return bits;
    endfunction

endpackage

// ===== rtl/core/morse_letter_keyer_unit.sv =====
// morse_letter_keyer_unit: top level of the morse letter keyer
// depends on mlk_pkg, mlk_ctrl and mlk_datapath
//
// usage:
//   an item is taken at a rising edge with start high and busy low; letter
//   carries one ascii byte, lowercase a to z keys a letter
//   each result (led_on, duration_ms, bad_letter, last) is shown for one cycle
//   with strobe high; the receiver cannot stall, results are never held
//   a letter of n symbols gives 2n+1 results on consecutive cycles, the first
//   registered from the first gap state after the item is taken; last marks the closing gap
//   a byte outside a to z gives one result with bad_letter and last set
//   busy stays high until the last result is registered; the next item can
//   be taken in the cycle its last result is shown; the sequencer steps one
//   segment per cycle
//   config: cfg_index/cfg_data written when cfg_valid is high; cfg_ready is
//   always high; indexes beyond 3 are ignored; write only while idle
//   reset (rst_n low) clears the sequencer and strobe and loads the timing
//   registers with 400, 400, 1200 and 600 ms
module morse_letter_keyer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mlk_pkg::LETTER_W-1:0]       letter,
    output logic                               busy,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlk_pkg::DUR_W-1:0]          cfg_data,
    output logic                               strobe,
    output logic                               led_on,
    output logic [mlk_pkg::DUR_W-1:0]          duration_ms,
    output logic                               bad_letter,
    output logic                               last
);

    mlk_pkg::mlk_cmd_t    cmd;
    mlk_pkg::mlk_status_t status;

    assign cfg_ready = 1'b1;

    mlk_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mlk_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .letter      (letter),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .strobe      (strobe),
        .led_on      (led_on),
        .duration_ms (duration_ms),
        .bad_letter  (bad_letter),
        .last        (last)
    );

endmodule

// ===== rtl/core/mlk_ctrl.sv =====
// mlk_ctrl: sequencer that steps through the segments of one letter
// depends on mlk_pkg for the command and status types
module mlk_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mlk_pkg::mlk_status_t status,
    output mlk_pkg::mlk_cmd_t    cmd,
    output logic                 busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GAP   = 3'd1;
    localparam logic [2:0] ST_MARK  = 3'd2;
    localparam logic [2:0] ST_CLOSE = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_bad ? ST_BAD : ST_GAP;
                end
            end
            ST_GAP:
            begin
                cmd.emit_gap = 1'b1;
                state_next   = ST_MARK;
            end
            ST_MARK:
            begin
                cmd.emit_mark = 1'b1;
                state_next    = status.last_sym ? ST_CLOSE : ST_GAP;
            end
            ST_CLOSE:
            begin
                cmd.emit_close = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_BAD:
            begin
                cmd.emit_bad = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/mlk_datapath.sv =====
// mlk_datapath: timing registers, code lookup, symbol shifter and result registers
// depends on mlk_pkg for tables, constants and the command and status types
module mlk_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mlk_pkg::LETTER_W-1:0]        letter,
    input  logic                                cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlk_pkg::DUR_W-1:0]           cfg_data,
    input  mlk_pkg::mlk_cmd_t                   cmd,
    output mlk_pkg::mlk_status_t                status,
    output logic                                strobe,
    output logic                                led_on,
    output logic [mlk_pkg::DUR_W-1:0]           duration_ms,
    output logic                                bad_letter,
    output logic                                last
);

    logic [mlk_pkg::DUR_W-1:0]     symbol_gap_reg;
    logic [mlk_pkg::DUR_W-1:0]     dot_reg;
    logic [mlk_pkg::DUR_W-1:0]     dash_reg;
    logic [mlk_pkg::DUR_W-1:0]     letter_gap_reg;

    logic [mlk_pkg::SYM_MAX-1:0]   bits_reg;
    logic [mlk_pkg::SYM_MAX-1:0]   bits_next;
    logic [mlk_pkg::SYM_CNT_W-1:0] cnt_reg;
    logic [mlk_pkg::SYM_CNT_W-1:0] cnt_next;

    logic                          strobe_reg;
    logic                          led_reg;
    logic [mlk_pkg::DUR_W-1:0]     dur_reg;
    logic                          bad_reg;
    logic                          last_reg;

    logic [mlk_pkg::LETTER_W-1:0]  offset;
    logic [mlk_pkg::IDX_W-1:0]     idx;
    logic [mlk_pkg::SYM_CNT_W-1:0] len;
    logic [mlk_pkg::SYM_MAX-1:0]   raw_bits;

    assign offset = letter - mlk_pkg::LETTER_FIRST;
    assign idx    = offset[mlk_pkg::IDX_W-1:0];
    assign len    = mlk_pkg::code_len(idx);
    assign raw_bits = mlk_pkg::code_bits(idx);

    assign status.in_bad   = (letter < mlk_pkg::LETTER_FIRST) ||
                             (letter > mlk_pkg::LETTER_LAST);
    assign status.last_sym = (cnt_reg == mlk_pkg::SYM_CNT_W'(1));

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_gap_reg <= mlk_pkg::SYMBOL_GAP_RST;
            dot_reg        <= mlk_pkg::DOT_RST;
            dash_reg       <= mlk_pkg::DASH_RST;
            letter_gap_reg <= mlk_pkg::LETTER_GAP_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mlk_pkg::REG_SYMBOL_GAP)
            begin
                symbol_gap_reg <= cfg_data;
            end
            if (cfg_index == mlk_pkg::REG_DOT)
            begin
                dot_reg <= cfg_data;
            end
            if (cfg_index == mlk_pkg::REG_DASH)
            begin
                dash_reg <= cfg_data;
            end
            if (cfg_index == mlk_pkg::REG_LETTER_GAP)
            begin
                letter_gap_reg <= cfg_data;
            end
        end
    end

    // symbols left-aligned so the next one is always the top bit
    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            bits_next = raw_bits << (mlk_pkg::SYM_CNT_W'(mlk_pkg::SYM_MAX) - len);
            cnt_next  = len;
        end
        else if (cmd.emit_mark)
        begin
            bits_next = {bits_reg[mlk_pkg::SYM_MAX-2:0], 1'b0};
            cnt_next  = cnt_reg - mlk_pkg::SYM_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_gap | cmd.emit_mark | cmd.emit_close | cmd.emit_bad;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        priority if (cmd.emit_gap)
        begin
            led_reg  <= 1'b0;
            dur_reg  <= symbol_gap_reg;
            bad_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_mark)
        begin
            led_reg  <= 1'b1;
            dur_reg  <= bits_reg[mlk_pkg::SYM_MAX-1] ? dash_reg : dot_reg;
            bad_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_close)
        begin
            led_reg  <= 1'b0;
            dur_reg  <= letter_gap_reg;
            bad_reg  <= 1'b0;
            last_reg <= 1'b1;
        end
        else if (cmd.emit_bad)
        begin
            led_reg  <= 1'b0;
            dur_reg  <= '0;
            bad_reg  <= 1'b1;
            last_reg <= 1'b1;
        end
        else
        begin
            led_reg  <= led_reg;
            dur_reg  <= dur_reg;
            bad_reg  <= bad_reg;
            last_reg <= last_reg;
        end
    end

    assign strobe      = strobe_reg;
    assign led_on      = led_reg;
    assign duration_ms = dur_reg;
    assign bad_letter  = bad_reg;
    assign last        = last_reg;

endmodule
